@@ hw/rtl/a85_pkg.sv @@
// a85_pkg: shared types and constants for the ASCII85 line encoder.
// Used by a85_div85 and ascii85_line_encoder_core; no dependencies.
`default_nettype none

package a85_pkg;

  // Input item kind, carried on in_tuser
  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } a85_op_t;

  // Characters
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_Z     = 8'h7A;  // 'z'
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_LF    = 8'h0A;  // newline

  // Digit value that prints as '%'
  localparam logic [6:0] PCT_DIGIT = 7'd4;

  localparam logic [7:0] LINE_WIDTH_RST   = 8'd75;
  localparam logic [7:0] LINE_WIDTH_FLOOR = 8'd5;

  // x / 85 == (x * DIV85_MAGIC) >> DIV85_SHIFT, exact for any 32-bit x
  localparam logic [31:0] DIV85_MAGIC = 32'd3233857729;
  localparam int unsigned DIV85_SHIFT = 38;
  localparam int unsigned QUOT_W      = 64 - DIV85_SHIFT;
  localparam logic [31:0] QUOT_MAX    = 32'd50529027;  // 0xFFFFFFFF / 85

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [6:0]        rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/a85_div85.sv @@
// a85_div85: divide-by-85 unit, one registered multiply then remainder.
// Depends on a85_pkg (reciprocal constant, result struct).
`default_nettype none

module a85_div85
  import a85_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  output div_res_t         res
);

  logic [63:0] prod_r;
  logic [31:0] dvd_r;
  logic        vld_r;

  logic [QUOT_W-1:0] quot;
  logic [31:0]       quot32;
  logic [31:0]       q_x85;
  logic [31:0]       rem32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
    prod_r <= 64'(dividend) * 64'(DIV85_MAGIC);
    dvd_r  <= dividend;
  end

  // q*85 = q*64 + q*16 + q*4 + q
  always_comb begin
    quot   = prod_r[63:DIV85_SHIFT];
    quot32 = 32'(quot);
    q_x85  = (quot32 << 6) + (quot32 << 4) + (quot32 << 2) + quot32;
    rem32  = dvd_r - q_x85;
    res.done = vld_r;
    res.quot = quot;
    res.rem  = rem32[6:0];
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (rem32 < 32'd85))
    else $error("div85 remainder out of range");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (quot32 <= QUOT_MAX))
    else $error("div85 quotient out of range");

endmodule

`default_nettype wire

@@ hw/rtl/ascii85_line_encoder_core.sv @@
// ascii85_line_encoder_core: streaming ASCII85 encoder with line wrapping.
// Depends on a85_pkg and a85_div85.
`default_nettype none

// Bytes enter on in_* (in_tuser = OP_DATA) and are packed four to a group,
// most significant first; a data byte taken while four are held first
// flushes the full group as five base-85 digits ('!' + digit), or 'z' for
// an all-zero group. An end item (in_tuser = OP_END) zero-pads a partial
// group of n bytes, emits n+1 digits, then "~>" and a newline, and clears
// the column count. A newline goes out ahead of any digit or 'z' once the
// column count reaches cfg max_line_width (values below 5 act as 5), but
// never ahead of a '%' digit. out_tlast marks the final character of the
// item that caused it. A flush computes its five digits least significant
// first through one shared divide-by-85 unit (skipped for a 'z' group),
// then sends one character per cycle while out_tready allows (digits plus
// any inserted newlines); an end item then adds the three terminator
// characters. The block takes no new item while a flush or terminator is in
// progress, but the output register lets it take the next item while the
// last character still waits on out_tready. cfg is always ready; write it
// only while the block is idle.
module ascii85_line_encoder_core
  import a85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input items
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] opcode
  // result items
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast,  // last_of_run
  // configuration: max_line_width
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_ISSUE,
    S_DIV_WAIT,
    S_EMIT,
    S_TERM
  } state_t;

  state_t      state_r;
  logic [7:0]  width_r;      // max_line_width register
  logic [31:0] word_r;       // group being packed
  logic [2:0]  cnt_r;        // bytes held, 0..4
  logic [7:0]  col_r;        // line column
  logic [31:0] work_r;       // running quotient during digit extraction
  logic [2:0]  dcnt_r;       // digit slot being produced, 4 down to 0
  logic [6:0]  dig_r [5];    // digits, slot 0 most significant
  logic [2:0]  idx_r;        // digit slot being sent
  logic        zgrp_r;       // flush is a single 'z'
  logic        is_end_r;     // flush belongs to an end item
  logic [7:0]  pend_r;       // byte that starts the next group
  logic [1:0]  tidx_r;       // terminator position
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;

  logic        in_acc;
  logic        can_load;
  logic        load_out;     // a character enters the output register
  logic [31:0] padded;
  logic        zero_full;
  logic [7:0]  limit;
  logic [6:0]  dig_rd;
  logic        may_wrap;
  logic        wrap_now;
  logic        grp_last;
  logic [7:0]  emit_char;
  div_res_t    div_res;

  a85_div85 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIV_ISSUE),
    .dividend (work_r),
    .res      (div_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign in_acc     = in_tvalid && in_tready;
  assign can_load   = !out_valid_r || out_tready;
  assign load_out   = ((state_r == S_EMIT) || (state_r == S_TERM)) && can_load;

  always_comb begin
    // zero-pad a partial group up to four bytes
    unique case (cnt_r)
      3'd1:    padded = {word_r[7:0], 24'b0};
      3'd2:    padded = {word_r[15:0], 16'b0};
      3'd3:    padded = {word_r[23:0], 8'b0};
      default: padded = word_r;
    endcase
    zero_full = (cnt_r == 3'd4) && (word_r == 32'd0);
    limit     = (width_r < LINE_WIDTH_FLOOR) ? LINE_WIDTH_FLOOR : width_r;
    dig_rd    = dig_r[idx_r];
    may_wrap  = zgrp_r || (dig_rd != PCT_DIGIT);
    wrap_now  = may_wrap && (col_r >= limit);
    grp_last  = zgrp_r || (idx_r == cnt_r);
    emit_char = zgrp_r ? CH_Z : (8'({1'b0, dig_rd}) + CH_BANG);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= LINE_WIDTH_RST;
      word_r      <= 32'd0;
      cnt_r       <= 3'd0;
      col_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        width_r <= cfg_data;
      end
      // a new character replaces the one just taken, else the register drains
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (a85_op_t'(in_tuser) == OP_END) begin
              is_end_r <= 1'b1;
              tidx_r   <= 2'd0;
              if (cnt_r == 3'd0) begin
                state_r <= S_TERM;
              end else begin
                work_r  <= padded;
                zgrp_r  <= zero_full;
                idx_r   <= 3'd0;
                dcnt_r  <= 3'd4;
                state_r <= zero_full ? S_EMIT : S_DIV_ISSUE;
              end
            end else if (cnt_r == 3'd4) begin
              is_end_r <= 1'b0;
              pend_r   <= in_tdata;
              work_r   <= word_r;
              zgrp_r   <= zero_full;
              idx_r    <= 3'd0;
              dcnt_r   <= 3'd4;
              state_r  <= zero_full ? S_EMIT : S_DIV_ISSUE;
            end else begin
              word_r <= {word_r[23:0], in_tdata};
              cnt_r  <= cnt_r + 3'd1;
            end
          end
        end

        S_DIV_ISSUE: begin
          state_r <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_res.done) begin
            dig_r[dcnt_r] <= div_res.rem;
            work_r        <= 32'(div_res.quot);
            if (dcnt_r == 3'd0) begin
              state_r <= S_EMIT;
            end else begin
              dcnt_r  <= dcnt_r - 3'd1;
              state_r <= S_DIV_ISSUE;
            end
          end
        end

        S_EMIT: begin
          if (can_load) begin
            if (wrap_now) begin
              // line full: newline first, then the same digit
              out_data_r <= CH_LF;
              out_last_r <= 1'b0;
              col_r      <= 8'd0;
            end else begin
              out_data_r <= emit_char;
              out_last_r <= grp_last && !is_end_r;
              col_r      <= col_r + 8'd1;
              if (grp_last) begin
                if (is_end_r) begin
                  state_r <= S_TERM;
                end else begin
                  word_r  <= {24'b0, pend_r};
                  cnt_r   <= 3'd1;
                  state_r <= S_IDLE;
                end
              end else begin
                idx_r <= idx_r + 3'd1;
              end
            end
          end
        end

        S_TERM: begin
          if (can_load) begin
            tidx_r <= tidx_r + 2'd1;
            priority if (tidx_r == 2'd0) begin
              out_data_r <= CH_TILDE;
              out_last_r <= 1'b0;
            end else if (tidx_r == 2'd1) begin
              out_data_r <= CH_GT;
              out_last_r <= 1'b0;
            end else begin
              out_data_r <= CH_LF;
              out_last_r <= 1'b1;
              col_r      <= 8'd0;
              word_r     <= 32'd0;
              cnt_r      <= 3'd0;
              state_r    <= S_IDLE;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("group byte count above four");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (a85_op_t'(in_tuser) == OP_END)) |=> !in_tready)
    else $error("end item did not start a flush or terminator");

  a_term_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && (out_data_r == CH_LF)) |-> (col_r == 8'd0))
    else $error("column not cleared by terminator");

  a_wrap_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && can_load && may_wrap && !wrap_now) |-> (col_r < limit))
    else $error("digit sent past line limit");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for ascii85_line_encoder_core (ASCII85 encoder with line wrap).
// Depends on a85_pkg and the core RTL; carries its own encoder predictor and scoreboard.
module tb;
  import a85_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
  localparam int HOLD_AFTER  = 100;   // input items taken before the long sink hold
  localparam int HOLD_CYCLES = 200;
  localparam int CFG_SETTLE  = 16;    // covers a data byte still in flight
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 23;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } a85_char_t;

  // One row of the directed table; typed rows carry their expected characters
  typedef struct {
    a85_op_t    op;
    logic [7:0] data;
    bit         typed;
    string      chars;
  } stim_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;  // [7:0] data_byte
  logic       in_tuser   = 1'b0;  // [0] opcode
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;  // [7:0] out_char
  logic       out_tlast;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = '0;

  ascii85_line_encoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scoreboard: characters still owed by the block, oldest first
  a85_char_t pending_chars[$];
  a85_char_t item_chars[$];  // scratch: characters caused by one item
  stim_row_t directed_rows[$];

  // Predictor state
  logic [31:0] pred_word;
  logic [2:0]  pred_count;
  logic [7:0]  pred_col;
  logic [7:0]  pred_width;

  // Random group generator state
  logic [1:0]  gen_pos;
  logic [31:0] gen_group;

  int errors        = 0;
  int items_taken   = 0;
  int chars_checked = 0;
  int z_seen        = 0;
  int wraps_seen    = 0;
  int cfg_writes    = 0;
  int stall_cycles  = 0;
  bit tx_steady     = 1'b0;
  bit held          = 1'b0;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Newline goes ahead of a wrappable char once the column hits the limit;
  // widths below the floor behave as the floor.
  task automatic put_char(input logic [7:0] ch, input bit may_wrap);
    logic [7:0] limit;
    limit = (pred_width < LINE_WIDTH_FLOOR) ? LINE_WIDTH_FLOOR : pred_width;
    if (may_wrap && pred_col >= limit) begin
      item_chars.push_back('{CH_LF, 1'b0});
      pred_col = '0;
    end
    item_chars.push_back('{ch, 1'b0});
    pred_col = pred_col + 8'd1;
  endtask

  // count+1 digits, most significant first; 'z' only for a full zero group.
  // A '%' digit never takes a newline ahead of it.
  task automatic flush_group();
    logic [31:0] v;
    logic [7:0]  digs [5];
    v = pred_word;
    for (int i = 4; i >= 0; i--) begin
      digs[i] = 8'(v % 85) + CH_BANG;
      v = v / 85;
    end
    if (pred_word == '0 && pred_count == 3'd4) begin
      put_char(CH_Z, 1'b1);
    end else begin
      for (int i = 0; i <= int'(pred_count); i++)
        put_char(digs[i], digs[i] != (CH_BANG + 8'(PCT_DIGIT)));
    end
    pred_word  = '0;
    pred_count = '0;
  endtask

  task automatic encode_item(input a85_op_t op, input logic [7:0] b);
    item_chars.delete();
    if (op == OP_DATA) begin
      if (pred_count == 3'd4) flush_group();
      pred_word  = {pred_word[23:0], b};
      pred_count = pred_count + 3'd1;
    end else begin
      if (pred_count != 3'd0) begin
        pred_word = pred_word << (8 * (4 - int'(pred_count)));
        flush_group();
      end
      // terminator does not count toward the column
      item_chars.push_back('{CH_TILDE, 1'b0});
      item_chars.push_back('{CH_GT, 1'b0});
      item_chars.push_back('{CH_LF, 1'b0});
      pred_col   = '0;
      pred_word  = '0;
      pred_count = '0;
    end
    if (item_chars.size() > 0) item_chars[item_chars.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the handshake.
  task automatic send_item(input a85_op_t op, input logic [7:0] b,
                           input bit typed, input string chars);
    int gap;
    if (items_taken % 16 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    encode_item(op, b);
    if (typed) begin
      for (int i = 0; i < chars.len(); i++)
        pending_chars.push_back('{chars[i], i == chars.len() - 1});
    end else begin
      foreach (item_chars[i]) pending_chars.push_back(item_chars[i]);
    end
    items_taken++;
    @(negedge clk);
  endtask

  function automatic void add_row(input a85_op_t op, input logic [7:0] d,
                                  input bit typed, input string chars);
    stim_row_t r;
    r.op    = op;
    r.data  = d;
    r.typed = typed;
    r.chars = chars;
    directed_rows.push_back(r);
  endfunction

  // Group word shaped to exercise zero groups, '%' digits and byte extremes
  function automatic logic [31:0] make_group();
    logic [63:0] acc;
    int          pct_pos;
    int          mode;
    mode = $urandom_range(0, 9);
    acc  = '0;
    case (mode)
      0, 1: acc = '0;
      2, 3: begin
        // five base-85 digits, one forced to the '%' value; top digit kept in range
        pct_pos = $urandom_range(0, 4);
        for (int i = 0; i < 5; i++) begin
          acc = acc * 85;
          if (i == pct_pos) acc = acc + PCT_DIGIT;
          else acc = acc + ((i == 0) ? $urandom_range(0, 81) : $urandom_range(0, 84));
        end
      end
      4: for (int i = 0; i < 4; i++) acc = {acc[55:0], ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      default: acc = {32'd0, $urandom};
    endcase
    return acc[31:0];
  endfunction

  // Random items: mostly groups of data bytes, ends at random positions
  task automatic run_phase(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(OP_END, 8'($urandom_range(0, 255)), 1'b0, "");
        gen_pos = '0;
      end else begin
        if (gen_pos == 2'd0) gen_group = make_group();
        send_item(OP_DATA, gen_group[31 - 8*gen_pos -: 8], 1'b0, "");
        gen_pos = gen_pos + 2'd1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  // Only while idle: every owed char delivered, plus settle time
  task automatic write_line_width(input logic [7:0] w);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    pred_width = w;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] phase_widths [9];
    logic [7:0] w;
    pred_word  = '0;
    pred_count = '0;
    pred_col   = '0;
    pred_width = LINE_WIDTH_RST;
    gen_pos    = '0;
    gen_group  = '0;
    // extremes first: 0 and 1 act as the floor, 255 is the widest
    phase_widths = '{8'd255, 8'd0, 8'd1, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, LINE_WIDTH_RST};

    // Directed table (reset width 75, never reached here)
    add_row(OP_END,  8'hFF, 1'b1, "~>\n");          // end on empty group
    add_row(OP_DATA, 8'hFF, 1'b1, "");
    add_row(OP_DATA, 8'hFF, 1'b1, "");
    add_row(OP_DATA, 8'hFF, 1'b1, "");
    add_row(OP_DATA, 8'hFF, 1'b1, "");
    add_row(OP_END,  8'h00, 1'b1, "s8W-!~>\n");     // all-ones full group
    add_row(OP_DATA, 8'h00, 1'b1, "");
    add_row(OP_DATA, 8'h00, 1'b1, "");
    add_row(OP_DATA, 8'h00, 1'b1, "");
    add_row(OP_DATA, 8'h00, 1'b1, "");
    add_row(OP_END,  8'h5A, 1'b1, "z~>\n");         // full zero group
    add_row(OP_DATA, 8'h00, 1'b1, "");
    add_row(OP_END,  8'hA5, 1'b1, "!!~>\n");        // zero partial group: no 'z'
    add_row(OP_DATA, 8'h80, 1'b1, "");
    add_row(OP_DATA, 8'h01, 1'b1, "");
    add_row(OP_DATA, 8'h55, 1'b1, "");
    add_row(OP_DATA, 8'hAA, 1'b1, "");
    add_row(OP_DATA, 8'h7F, 1'b0, "");              // fifth byte flushes the group
    add_row(OP_DATA, 8'h00, 1'b0, "");
    add_row(OP_DATA, 8'h00, 1'b0, "");
    add_row(OP_DATA, 8'h00, 1'b0, "");
    add_row(OP_DATA, 8'h00, 1'b0, "");              // flushes 7F000000
    add_row(OP_END,  8'hFF, 1'b0, "");              // one-byte partial flush

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].chars);

    for (int p = 0; p < 9; p++) begin
      w = (p == 7) ? 8'($urandom_range(8, 254)) : phase_widths[p];
      write_line_width(w);
      run_phase(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d items (%0d directed), %0d chars checked, %0d width writes",
             items_taken, directed_rows.size(), chars_checked, cfg_writes);
    $display("Saw %0d 'z' groups, %0d inserted newlines, one %0d-cycle sink hold",
             z_seen, wraps_seen, HOLD_CYCLES);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random backpressure with one long hold to fill the block
  // ---------------------------------------------------------------------------
  initial begin : sink
    int gap;
    int seen;
    bit steady;
    seen   = 0;
    steady = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && items_taken >= HOLD_AFTER) begin
        // sender keeps offering; input must stall once the output is full
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (seen % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      seen++;
    end
  end

  // Check every accepted char against the oldest owed one
  always @(posedge clk) begin
    a85_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h last=%0b", out_tdata, out_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch)
          report_mismatch($sformatf("char %02h, expected %02h", out_tdata, want.ch));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("tlast %b on char %02h, expected %b",
                                    out_tlast, want.ch, want.last));
        chars_checked++;
        if (want.ch == CH_Z) z_seen++;
        if (want.ch == CH_LF && !want.last) wraps_seen++;
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d chars still owed",
               STALL_LIMIT, pending_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
